### sv/dlr_pkg.sv
package dlr_pkg;

  // Field widths
  localparam int COORD_W  = 20;  // signed Q11.8 endpoint
  localparam int DELTA_W  = 21;  // endpoint difference, also |d| and steps
  localparam int ACC_W    = 32;  // signed Q.16 position accumulator
  localparam int INC_W    = 18;  // signed Q.16 increment
  localparam int QUO_W    = 17;  // increment magnitude, at most 1.0 in Q.16
  localparam int REM_W    = DELTA_W + 1;
  localparam int DIV_CNT_W = $clog2(QUO_W);
  localparam int FRAC_W   = 8;   // fraction bits of the endpoints
  localparam int TRUNC_W  = ACC_W - 16;
  localparam int CNT_W    = 14;
  localparam int COLOUR_W = 32;
  localparam int DIM_W    = 13;
  localparam int PIX_W    = 12;
  localparam int ADDR_W   = 24;
  localparam int PROD_W   = 2 * DIM_W;

  // Pixel count cap per line
  localparam logic [CNT_W-1:0] MAX_LINE_PIXELS = 14'd10000;

  // Screen size after reset
  localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;

  // Request function codes
  localparam logic FUNC_BEGIN = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // Queued request kinds
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DROP  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] stop_x;
    logic signed [COORD_W-1:0] stop_y;
    logic [COLOUR_W-1:0]       colour;
  } entry_t;

endpackage

### sv/dda_line_rasterizer_unit.sv
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid / in_ready      | func, endpoints, behind flags, colour
// out     | output    | out_valid / out_ready    | pixel x/y, address, write enable, colour, last
// cfg     | input     | cfg_valid / cfg_ready    | cfg_index, cfg_wdata (always ready)
//
// Requests pass through a two-entry queue to a sequencer that handles one at a time.
// A begin request stays in the sequencer until the bit-serial increment divider finishes.
// A tick that draws steps through dequeue, position sample, clip and row multiply,
// address add; a tick with no line or a drop is done at dequeue.
// Reset (rst_n low, synchronous) empties the queue and output register, ends any
// line, and sets the screen to 640 x 480.
// An output stall holds the sequencer in its last pixel cycle; the queue keeps
// taking requests until full.
module dda_line_rasterizer_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_func,
  input  logic signed [dlr_pkg::COORD_W-1:0]   in_start_x,
  input  logic signed [dlr_pkg::COORD_W-1:0]   in_start_y,
  input  logic signed [dlr_pkg::COORD_W-1:0]   in_stop_x,
  input  logic signed [dlr_pkg::COORD_W-1:0]   in_stop_y,
  input  logic                                 in_start_behind,
  input  logic                                 in_stop_behind,
  input  logic [dlr_pkg::COLOUR_W-1:0]         in_line_colour_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dlr_pkg::PIX_W-1:0]     out_pixel_x,
  output logic signed [dlr_pkg::PIX_W-1:0]     out_pixel_y,
  output logic [dlr_pkg::ADDR_W-1:0]           out_pixel_addr,
  output logic                                 out_write_enable,
  output logic [dlr_pkg::COLOUR_W-1:0]         out_pixel_colour,
  output logic                                 out_last_pixel,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [dlr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [dlr_pkg::DIM_W-1:0]            cfg_wdata
);

  logic [dlr_pkg::DIM_W-1:0] screen_width_r;
  logic [dlr_pkg::DIM_W-1:0] screen_height_r;
  logic                      q_valid;
  logic                      q_pop;
  dlr_pkg::entry_t           q_head;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= dlr_pkg::WIDTH_RESET;
      screen_height_r <= dlr_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        dlr_pkg::CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
        dlr_pkg::CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dlr_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_start_x        (in_start_x),
    .in_start_y        (in_start_y),
    .in_stop_x         (in_stop_x),
    .in_stop_y         (in_stop_y),
    .in_start_behind   (in_start_behind),
    .in_stop_behind    (in_stop_behind),
    .in_line_colour_in (in_line_colour_in),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .q_pop             (q_pop)
  );

  dlr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .screen_width     (screen_width_r),
    .screen_height    (screen_height_r),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_addr   (out_pixel_addr),
    .out_write_enable (out_write_enable),
    .out_pixel_colour (out_pixel_colour),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

### sv/dlr_front.sv
module dlr_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_func,
  input  logic signed [dlr_pkg::COORD_W-1:0]   in_start_x,
  input  logic signed [dlr_pkg::COORD_W-1:0]   in_start_y,
  input  logic signed [dlr_pkg::COORD_W-1:0]   in_stop_x,
  input  logic signed [dlr_pkg::COORD_W-1:0]   in_stop_y,
  input  logic                                 in_start_behind,
  input  logic                                 in_stop_behind,
  input  logic [dlr_pkg::COLOUR_W-1:0]         in_line_colour_in,
  output logic                                 q_valid,
  output dlr_pkg::entry_t                      q_head,
  input  logic                                 q_pop
);

  localparam int DEPTH = 2;

  dlr_pkg::entry_t entry_r [DEPTH];
  dlr_pkg::entry_t new_entry;
  logic            wr_ptr_r;
  logic            rd_ptr_r;
  logic [1:0]      count_r;
  logic            push;

  // Classify the request
  always_comb begin
    new_entry.start_x = in_start_x;
    new_entry.start_y = in_start_y;
    new_entry.stop_x  = in_stop_x;
    new_entry.stop_y  = in_stop_y;
    new_entry.colour  = in_line_colour_in;
    if (in_func == dlr_pkg::FUNC_TICK) begin
      new_entry.kind = dlr_pkg::KIND_TICK;
    end else if (in_start_behind || in_stop_behind) begin
      new_entry.kind = dlr_pkg::KIND_DROP;
    end else begin
      new_entry.kind = dlr_pkg::KIND_BEGIN;
    end
  end

  assign in_ready = (count_r != 2'(DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_head   = entry_r[rd_ptr_r];

  // Queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 2'd1;
      end else if (!push && q_pop) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= new_entry;
    end
  end

endmodule

### sv/dlr_div.sv
module dlr_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [dlr_pkg::DELTA_W-1:0]   num,
  input  logic [dlr_pkg::DELTA_W-1:0]   den,
  output logic                          done,
  output logic [dlr_pkg::QUO_W-1:0]     quo
);

  // Restoring division of (num << 16) by den, num <= den, one bit a cycle
  logic                            busy_r;
  logic                            done_r;
  logic [dlr_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [dlr_pkg::REM_W-1:0]       rem_r;
  logic [dlr_pkg::DELTA_W-1:0]     den_r;
  logic [dlr_pkg::QUO_W-1:0]       quo_r;
  logic [dlr_pkg::REM_W:0]         diff;
  logic                            ge;
  logic [dlr_pkg::REM_W-1:0]       rem_after;

  assign diff      = {1'b0, rem_r} - {2'b00, den_r};
  assign ge        = !diff[dlr_pkg::REM_W];
  assign rem_after = ge ? diff[dlr_pkg::REM_W-1:0] : rem_r;

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= dlr_pkg::DIV_CNT_W'(dlr_pkg::QUO_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      quo_r <= '0;
    end else if (busy_r) begin
      quo_r <= {quo_r[dlr_pkg::QUO_W-2:0], ge};
      rem_r <= {rem_after[dlr_pkg::REM_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

### sv/dlr_back.sv
module dlr_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  dlr_pkg::entry_t                      q_head,
  output logic                                 q_pop,
  input  logic [dlr_pkg::DIM_W-1:0]            screen_width,
  input  logic [dlr_pkg::DIM_W-1:0]            screen_height,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dlr_pkg::PIX_W-1:0]     out_pixel_x,
  output logic signed [dlr_pkg::PIX_W-1:0]     out_pixel_y,
  output logic [dlr_pkg::ADDR_W-1:0]           out_pixel_addr,
  output logic                                 out_write_enable,
  output logic [dlr_pkg::COLOUR_W-1:0]         out_pixel_colour,
  output logic                                 out_last_pixel
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SET1 = 3'd1;
  localparam logic [2:0] S_SET2 = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_PIX1 = 3'd4;
  localparam logic [2:0] S_PIX2 = 3'd5;
  localparam logic [2:0] S_PIX3 = 3'd6;

  logic [2:0]                        state_r;
  logic [2:0]                        state_nxt;

  // Line state
  logic                              line_active_r;
  logic [dlr_pkg::CNT_W-1:0]         pixels_left_r;
  logic [dlr_pkg::ACC_W-1:0]         pos_x_acc_r;
  logic [dlr_pkg::ACC_W-1:0]         pos_y_acc_r;
  logic [dlr_pkg::INC_W-1:0]         inc_x_r;
  logic [dlr_pkg::INC_W-1:0]         inc_y_r;
  logic [dlr_pkg::COLOUR_W-1:0]      held_colour_r;

  // Setup working registers
  logic [dlr_pkg::DELTA_W-1:0]       dx_r;
  logic [dlr_pkg::DELTA_W-1:0]       dy_r;
  logic [dlr_pkg::DELTA_W-1:0]       adx_r;
  logic [dlr_pkg::DELTA_W-1:0]       ady_r;
  logic                              neg_x_r;
  logic                              neg_y_r;
  logic                              steps_zero_r;
  logic [dlr_pkg::DELTA_W-1:0]       steps;
  logic [dlr_pkg::CNT_W-1:0]         count_raw;
  logic [dlr_pkg::CNT_W-1:0]         count_sel;

  // Divider hookup
  logic                              div_start;
  logic                              done_x;
  logic                              done_y;
  logic [dlr_pkg::QUO_W-1:0]         quo_x;
  logic [dlr_pkg::QUO_W-1:0]         quo_y;
  logic [dlr_pkg::INC_W-1:0]         mag_x;
  logic [dlr_pkg::INC_W-1:0]         mag_y;

  // Pixel pipeline
  logic [dlr_pkg::TRUNC_W-1:0]       xt_nxt;
  logic [dlr_pkg::TRUNC_W-1:0]       yt_nxt;
  logic [dlr_pkg::TRUNC_W-1:0]       xt_r;
  logic [dlr_pkg::TRUNC_W-1:0]       yt_r;
  logic                              last_r;
  logic                              we_r;
  logic [dlr_pkg::PROD_W-1:0]        prod_r;
  logic [dlr_pkg::PROD_W-1:0]        addr_sum;

  // Output register
  logic                              out_valid_r;
  logic signed [dlr_pkg::PIX_W-1:0]  out_x_r;
  logic signed [dlr_pkg::PIX_W-1:0]  out_y_r;
  logic [dlr_pkg::ADDR_W-1:0]        out_addr_r;
  logic                              out_we_r;
  logic [dlr_pkg::COLOUR_W-1:0]      out_colour_r;
  logic                              out_last_r;
  logic                              out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign q_pop     = (state_r == S_IDLE) && q_valid;
  assign div_start = (state_r == S_SET2);

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (q_head.kind == dlr_pkg::KIND_BEGIN) begin
            state_nxt = S_SET1;
          end else if (q_head.kind == dlr_pkg::KIND_TICK && line_active_r) begin
            state_nxt = S_PIX1;
          end
        end
      end
      S_SET1: state_nxt = S_SET2;
      S_SET2: state_nxt = S_DIV;
      S_DIV: begin
        if (done_x) begin
          state_nxt = S_IDLE;
        end
      end
      S_PIX1: state_nxt = S_PIX2;
      S_PIX2: state_nxt = S_PIX3;
      S_PIX3: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Steps and pixel count
  assign steps     = (adx_r >= ady_r) ? adx_r : ady_r;
  assign count_raw = {1'b0, steps[dlr_pkg::DELTA_W-1:dlr_pkg::FRAC_W]} + 1'b1;
  assign count_sel = (count_raw > dlr_pkg::MAX_LINE_PIXELS) ?
                     dlr_pkg::MAX_LINE_PIXELS : count_raw;

  dlr_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (adx_r),
    .den   (steps),
    .done  (done_x),
    .quo   (quo_x)
  );

  dlr_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (ady_r),
    .den   (steps),
    .done  (done_y),
    .quo   (quo_y)
  );

  // Increment magnitudes; a zero-length line does not move
  assign mag_x = steps_zero_r ? '0 : {1'b0, quo_x};
  assign mag_y = steps_zero_r ? '0 : {1'b0, quo_y};

  // Truncate positions toward zero
  assign xt_nxt = pos_x_acc_r[dlr_pkg::ACC_W-1:16] +
                  dlr_pkg::TRUNC_W'(pos_x_acc_r[dlr_pkg::ACC_W-1] && (pos_x_acc_r[15:0] != '0));
  assign yt_nxt = pos_y_acc_r[dlr_pkg::ACC_W-1:16] +
                  dlr_pkg::TRUNC_W'(pos_y_acc_r[dlr_pkg::ACC_W-1] && (pos_y_acc_r[15:0] != '0));

  assign addr_sum = prod_r + {{(dlr_pkg::PROD_W-dlr_pkg::DIM_W){1'b0}},
                              xt_r[dlr_pkg::DIM_W-1:0]};

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      line_active_r <= 1'b0;
      pixels_left_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_head.kind == dlr_pkg::KIND_DROP) begin
        line_active_r <= 1'b0;
        pixels_left_r <= '0;
      end else if (state_r == S_SET2) begin
        line_active_r <= (count_sel != '0);
        pixels_left_r <= count_sel;
      end else if (state_r == S_PIX1) begin
        pixels_left_r <= pixels_left_r - 1'b1;
        if (pixels_left_r == dlr_pkg::CNT_W'(1)) begin
          line_active_r <= 1'b0;
        end
      end
      if (state_r == S_PIX3 && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    // Begin request: load start point and colour, take differences
    if (q_pop && q_head.kind == dlr_pkg::KIND_BEGIN) begin
      dx_r <= {q_head.stop_x[dlr_pkg::COORD_W-1], q_head.stop_x} -
              {q_head.start_x[dlr_pkg::COORD_W-1], q_head.start_x};
      dy_r <= {q_head.stop_y[dlr_pkg::COORD_W-1], q_head.stop_y} -
              {q_head.start_y[dlr_pkg::COORD_W-1], q_head.start_y};
      pos_x_acc_r <= {{(dlr_pkg::ACC_W-dlr_pkg::COORD_W-dlr_pkg::FRAC_W)
                       {q_head.start_x[dlr_pkg::COORD_W-1]}},
                      q_head.start_x, {dlr_pkg::FRAC_W{1'b0}}};
      pos_y_acc_r <= {{(dlr_pkg::ACC_W-dlr_pkg::COORD_W-dlr_pkg::FRAC_W)
                       {q_head.start_y[dlr_pkg::COORD_W-1]}},
                      q_head.start_y, {dlr_pkg::FRAC_W{1'b0}}};
      held_colour_r <= q_head.colour;
    end
    // Magnitudes and signs
    if (state_r == S_SET1) begin
      neg_x_r <= dx_r[dlr_pkg::DELTA_W-1];
      neg_y_r <= dy_r[dlr_pkg::DELTA_W-1];
      adx_r   <= dx_r[dlr_pkg::DELTA_W-1] ? -dx_r : dx_r;
      ady_r   <= dy_r[dlr_pkg::DELTA_W-1] ? -dy_r : dy_r;
    end
    if (state_r == S_SET2) begin
      steps_zero_r <= (steps == '0);
    end
    // Increments once the quotients are in
    if (state_r == S_DIV && done_x) begin
      inc_x_r <= neg_x_r ? -mag_x : mag_x;
      inc_y_r <= neg_y_r ? -mag_y : mag_y;
    end
    // Pixel: sample position, then step the line
    if (state_r == S_PIX1) begin
      xt_r        <= xt_nxt;
      yt_r        <= yt_nxt;
      last_r      <= (pixels_left_r == dlr_pkg::CNT_W'(1));
      pos_x_acc_r <= pos_x_acc_r + {{(dlr_pkg::ACC_W-dlr_pkg::INC_W){inc_x_r[dlr_pkg::INC_W-1]}},
                                    inc_x_r};
      pos_y_acc_r <= pos_y_acc_r + {{(dlr_pkg::ACC_W-dlr_pkg::INC_W){inc_y_r[dlr_pkg::INC_W-1]}},
                                    inc_y_r};
    end
    // Clip test and row offset
    if (state_r == S_PIX2) begin
      we_r   <= !xt_r[dlr_pkg::TRUNC_W-1] && !yt_r[dlr_pkg::TRUNC_W-1] &&
                (xt_r[dlr_pkg::TRUNC_W-2:0] <
                 {{(dlr_pkg::TRUNC_W-1-dlr_pkg::DIM_W){1'b0}}, screen_width}) &&
                (yt_r[dlr_pkg::TRUNC_W-2:0] <
                 {{(dlr_pkg::TRUNC_W-1-dlr_pkg::DIM_W){1'b0}}, screen_height});
      prod_r <= yt_r[dlr_pkg::DIM_W-1:0] * screen_width;
    end
    // Result into the output register
    if (state_r == S_PIX3 && out_free) begin
      out_x_r      <= xt_r[dlr_pkg::PIX_W-1:0];
      out_y_r      <= yt_r[dlr_pkg::PIX_W-1:0];
      out_addr_r   <= we_r ? addr_sum[dlr_pkg::ADDR_W-1:0] : '0;
      out_we_r     <= we_r;
      out_colour_r <= held_colour_r;
      out_last_r   <= last_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = out_x_r;
  assign out_pixel_y      = out_y_r;
  assign out_pixel_addr   = out_addr_r;
  assign out_write_enable = out_we_r;
  assign out_pixel_colour = out_colour_r;
  assign out_last_pixel   = out_last_r;

  // Both dividers run in lock step and only answer during setup
  assert property (@(posedge clk) disable iff (!rst_n) done_x == done_y)
    else $error("dividers out of step");
  assert property (@(posedge clk) disable iff (!rst_n) done_x |-> state_r == S_DIV)
    else $error("divider result outside setup");
  // Active flag tracks the remaining pixel count
  assert property (@(posedge clk) disable iff (!rst_n)
                   line_active_r == (pixels_left_r != '0))
    else $error("line_active and pixels_left disagree");
  // A pending result is never overwritten
  assert property (@(posedge clk) disable iff (!rst_n)
                   (state_r == S_PIX3 && !out_free) |=> state_r == S_PIX3 && out_valid_r)
    else $error("pixel dropped under output stall");
  // Queue is not popped while a request is in progress
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> state_r == S_IDLE)
    else $error("queue popped while busy");

endmodule
